@@ design/dtbm_pkg.sv @@
package dtbm_pkg;

	// Table sizes
	localparam int MAX_STATE_NUMBER = 512;
	localparam int TABLE_ENTRIES    = 4096;
	localparam int CLASS_MAP_SIZE   = 256;

	// Field widths
	localparam int OP_W     = 3;
	localparam int IDX_IN_W = 12;
	localparam int VALUE_W  = 10;
	localparam int STATE_W  = 10;
	localparam int CLASS_W  = 8;
	localparam int BYTE_W   = 8;

	// Memory address widths
	localparam int CMAP_W = $clog2(CLASS_MAP_SIZE);
	localparam int TIDX_W = $clog2(TABLE_ENTRIES);
	localparam int AIDX_W = $clog2(MAX_STATE_NUMBER);

	// Row base = state_count * (class - 1); index = base + state - 1
	localparam int BASE_W = STATE_W + CLASS_W;
	localparam int TSUM_W = BASE_W + 1;

	// Post-reset clearing sweep covers the largest table
	localparam int CLEAR_LEN_A = (TABLE_ENTRIES > MAX_STATE_NUMBER) ?
		TABLE_ENTRIES : MAX_STATE_NUMBER;
	localparam int CLEAR_LEN = (CLEAR_LEN_A > CLASS_MAP_SIZE) ? CLEAR_LEN_A : CLASS_MAP_SIZE;
	localparam int CLR_W     = $clog2(CLEAR_LEN);

	// Front-to-back queue
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	// Opcodes
	localparam logic [OP_W-1:0] OP_CLASS_WR = 3'd0;
	localparam logic [OP_W-1:0] OP_TRANS_WR = 3'd1;
	localparam logic [OP_W-1:0] OP_ACC_WR   = 3'd2;
	localparam logic [OP_W-1:0] OP_MATCH    = 3'd3;
	localparam logic [OP_W-1:0] OP_END      = 3'd4;

	// Configuration register indexes
	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] REG_STATE_COUNT = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_CLASS_COUNT = 2'd1;

	// Decoded item; write kinds are already range checked
	typedef struct packed {
		logic                class_wr;
		logic                trans_wr;
		logic                acc_wr;
		logic                match;
		logic                fin;
		logic [IDX_IN_W-1:0] tindex;
		logic [VALUE_W-1:0]  tvalue;
		logic [BYTE_W-1:0]   dbyte;
	} item_t;

	typedef struct packed {
		logic [STATE_W-1:0] state_count;
		logic [CLASS_W-1:0] class_count;
	} cfg_t;

endpackage

@@ design/dtbm_queue.sv @@
module dtbm_queue
	import dtbm_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  logic  push_valid,
	input  item_t push_item,
	output logic  push_ready,
	output logic  pop_valid,
	output item_t pop_item,
	input  logic  pop_ready
);

	item_t              entry_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0]  wr_ptr_q;
	logic [QPTR_W-1:0]  rd_ptr_q;
	logic [QCNT_W-1:0]  count_q;
	logic               push;
	logic               pop;

	assign push_ready = (count_q != QCNT_W'(QUEUE_DEPTH));
	assign pop_valid  = (count_q != '0);
	assign pop_item   = entry_q[rd_ptr_q];
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

@@ design/dtbm_front.sv @@
module dtbm_front
	import dtbm_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                busy,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [OP_W-1:0]     opcode,
	input  logic [IDX_IN_W-1:0] table_index,
	input  logic [VALUE_W-1:0]  table_value,
	input  logic [BYTE_W-1:0]   data_byte,
	input  logic                last,
	output logic                push_valid,
	output item_t               push_item,
	input  logic                push_ready
);

	logic        valid_q;
	item_t       item_q;
	item_t       dec;
	logic [31:0] idx_w;

	assign in_ready   = !busy && (!valid_q || push_ready);
	assign push_valid = valid_q;
	assign push_item  = item_q;
	assign idx_w      = 32'(table_index);

	// Decode opcode, drop out-of-range writes
	always_comb begin
		dec          = '0;
		dec.tindex   = table_index;
		dec.tvalue   = table_value;
		dec.dbyte    = data_byte;
		case (opcode)
			OP_CLASS_WR: dec.class_wr = (idx_w < 32'(CLASS_MAP_SIZE));
			OP_TRANS_WR: dec.trans_wr = (idx_w < 32'(TABLE_ENTRIES));
			OP_ACC_WR:   dec.acc_wr   = (idx_w < 32'(MAX_STATE_NUMBER));
			OP_MATCH: begin
				dec.match = 1'b1;
				dec.fin   = last;
			end
			OP_END:      dec.fin = 1'b1;
			default:     dec.fin = 1'b0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_q <= dec;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (in_valid && in_ready) begin
			valid_q <= 1'b1;
		end else if (push_ready) begin
			valid_q <= 1'b0;
		end
	end

endmodule

@@ design/dtbm_back.sv @@
module dtbm_back
	import dtbm_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  cfg_t  cfg,
	input  logic  q_valid,
	input  item_t q_item,
	output logic  q_pop,
	output logic  busy,
	output logic  out_valid,
	input  logic  out_ready,
	output logic  matched
);

	// Tables
	logic [CLASS_W-1:0] class_mem [CLASS_MAP_SIZE];
	logic [STATE_W-1:0] trans_mem [TABLE_ENTRIES];
	logic               acc_mem   [MAX_STATE_NUMBER];

	// Clearing sweep
	logic             clr_busy_q;
	logic [CLR_W-1:0] clr_cnt_q;
	logic [31:0]      clr_w;

	// Pipeline
	logic               valid_s2;
	item_t              item_s2;
	logic [CLASS_W-1:0] cls_s2;
	logic               valid_s3;
	item_t              item_s3;
	logic [BASE_W-1:0]  base_s3;
	logic               cls_bad_s3;
	logic               valid_s4;
	item_t              item_s4;
	logic               cls_bad_s4;
	logic               idx_bad_s4;
	logic [STATE_W-1:0] next_s4;

	// Matcher state and result register
	logic [STATE_W-1:0] state_q;
	logic               rejected_q;
	logic               out_valid_q;
	logic               acc_bit_q;
	logic               acc_ok_q;

	logic               go_s2;
	logic               go_s3;
	logic               go_s4;
	logic               stateful_s4;
	logic [TSUM_W-1:0]  tsum;
	logic               idx_ok;
	logic [31:0]        twr_w;
	logic [31:0]        awr_w;
	logic               adv_bad;
	logic [STATE_W-1:0] st_n;
	logic               rej_n;
	logic [31:0]        acc_addr_w;
	logic               acc_ok;

	assign busy      = clr_busy_q;
	assign out_valid = out_valid_q;
	assign matched   = acc_bit_q & acc_ok_q;
	assign clr_w     = 32'(clr_cnt_q);

	// Handshake between stages; s3 waits while s4 holds an item that moves the state
	assign stateful_s4 = item_s4.match || item_s4.fin;
	assign go_s4 = valid_s4 && (!item_s4.fin || !out_valid_q || out_ready);
	assign go_s3 = valid_s3 && (!valid_s4 || (go_s4 && !stateful_s4));
	assign go_s2 = valid_s2 && (!valid_s3 || go_s3);
	assign q_pop = q_valid && !clr_busy_q && (!valid_s2 || go_s2);

	// Transition index for the item in s3
	assign tsum   = TSUM_W'(base_s3) + TSUM_W'(state_q - 1'b1);
	assign idx_ok = (32'(tsum) < 32'(TABLE_ENTRIES));
	assign twr_w  = 32'(item_s3.tindex);
	assign awr_w  = 32'(item_s4.tindex);

	// State step for the item in s4
	always_comb begin
		adv_bad = cls_bad_s4 || idx_bad_s4 || (next_s4 == '0);
		st_n    = state_q;
		rej_n   = rejected_q;
		if (item_s4.match && !rejected_q) begin
			if (adv_bad) begin
				rej_n = 1'b1;
			end else begin
				st_n = next_s4;
			end
		end
		acc_addr_w = 32'(st_n - 1'b1);
		acc_ok     = !rej_n && (acc_addr_w < 32'(MAX_STATE_NUMBER));
	end

	// Class map: written and read as an item leaves the queue
	always_ff @(posedge clk) begin
		if (clr_busy_q) begin
			if (clr_w < 32'(CLASS_MAP_SIZE)) begin
				class_mem[clr_cnt_q[CMAP_W-1:0]] <= '0;
			end
		end else if (q_pop && q_item.class_wr) begin
			class_mem[q_item.tindex[CMAP_W-1:0]] <= q_item.tvalue[CLASS_W-1:0];
		end
		if (q_pop) begin
			cls_s2 <= class_mem[q_item.dbyte];
		end
	end

	// Transition table: written and read as an item moves s3 to s4
	always_ff @(posedge clk) begin
		if (clr_busy_q) begin
			if (clr_w < 32'(TABLE_ENTRIES)) begin
				trans_mem[clr_cnt_q[TIDX_W-1:0]] <= '0;
			end
		end else if (go_s3 && item_s3.trans_wr) begin
			trans_mem[twr_w[TIDX_W-1:0]] <= item_s3.tvalue;
		end
		if (go_s3) begin
			next_s4 <= trans_mem[tsum[TIDX_W-1:0]];
		end
	end

	// Accept flags: written and read as an item leaves s4
	always_ff @(posedge clk) begin
		if (clr_busy_q) begin
			if (clr_w < 32'(MAX_STATE_NUMBER)) begin
				acc_mem[clr_cnt_q[AIDX_W-1:0]] <= 1'b0;
			end
		end else if (go_s4 && item_s4.acc_wr) begin
			acc_mem[awr_w[AIDX_W-1:0]] <= item_s4.tvalue[0];
		end
		if (go_s4 && item_s4.fin) begin
			acc_bit_q <= acc_mem[acc_addr_w[AIDX_W-1:0]];
			acc_ok_q  <= acc_ok;
		end
	end

	// Pipeline payload
	always_ff @(posedge clk) begin
		if (q_pop) begin
			item_s2 <= q_item;
		end
		if (go_s2) begin
			item_s3    <= item_s2;
			base_s3    <= BASE_W'(cfg.state_count) * BASE_W'(cls_s2 - 1'b1);
			cls_bad_s3 <= (cls_s2 == '0) || (cls_s2 > cfg.class_count);
		end
		if (go_s3) begin
			item_s4    <= item_s3;
			cls_bad_s4 <= cls_bad_s3;
			idx_bad_s4 <= !idx_ok;
		end
	end

	// Control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_busy_q  <= 1'b1;
			clr_cnt_q   <= '0;
			valid_s2    <= 1'b0;
			valid_s3    <= 1'b0;
			valid_s4    <= 1'b0;
			out_valid_q <= 1'b0;
			state_q     <= STATE_W'(1);
			rejected_q  <= 1'b0;
		end else begin
			if (clr_busy_q) begin
				clr_cnt_q <= clr_cnt_q + 1'b1;
				if (clr_cnt_q == CLR_W'(CLEAR_LEN - 1)) begin
					clr_busy_q <= 1'b0;
				end
			end
			if (q_pop) begin
				valid_s2 <= 1'b1;
			end else if (go_s2) begin
				valid_s2 <= 1'b0;
			end
			if (go_s2) begin
				valid_s3 <= 1'b1;
			end else if (go_s3) begin
				valid_s3 <= 1'b0;
			end
			if (go_s3) begin
				valid_s4 <= 1'b1;
			end else if (go_s4) begin
				valid_s4 <= 1'b0;
			end
			if (go_s4 && item_s4.fin) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (go_s4 && stateful_s4) begin
				if (item_s4.fin) begin
					state_q    <= STATE_W'(1);
					rejected_q <= 1'b0;
				end else begin
					state_q    <= st_n;
					rejected_q <= rej_n;
				end
			end
		end
	end

	a_no_items_while_clearing: assert property (@(posedge clk) disable iff (!arst_n)
		clr_busy_q |-> !q_valid && !valid_s2 && !valid_s3 && !valid_s4)
		else $error("item in flight during table clearing");

	a_state_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		state_q != '0)
		else $error("current state is zero");

	a_finish_restarts: assert property (@(posedge clk) disable iff (!arst_n)
		go_s4 && item_s4.fin |=> state_q == STATE_W'(1) && !rejected_q && out_valid_q)
		else $error("string end did not restart matcher or post result");

	a_state_hazard: assert property (@(posedge clk) disable iff (!arst_n)
		go_s3 |-> !(valid_s4 && stateful_s4))
		else $error("transition read issued with state update pending");

endmodule

@@ design/dfa_table_byte_matcher.sv @@
// Table-driven DFA byte matcher. Load the class map (opcode 0), transition
// table (opcode 1) and accept flags (opcode 2) with table-write beats, set
// state_count and class_count on the cfg channel while idle, then stream
// subject bytes (opcode 3, last on the final byte) or an end beat (opcode 4).
// Each string end yields one out beat with matched. After reset all three
// tables are swept to zero; in_ready stays low during the sweep while cfg
// writes are taken. A front stage decodes and range-checks beats into a
// 2-entry queue; the back pipeline does class lookup, row-base multiply,
// transition read and accept read. Table writes and unused opcodes
// sustain one beat per cycle while no match or end beat is ahead and no
// out_ready stall holds an end beat; a beat behind a match or end beat waits
// in s3 until that beat has left s4, a pace set by the loop from the state
// register through the transition-table read back to the state register.
// A beat is registered in the front, queue, s2, s3 and s4 before out_valid.
module dfa_table_byte_matcher
	import dtbm_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [VALUE_W-1:0]   cfg_data,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic [OP_W-1:0]      opcode,
	input  logic [IDX_IN_W-1:0]  table_index,
	input  logic [VALUE_W-1:0]   table_value,
	input  logic [BYTE_W-1:0]    data_byte,
	input  logic                 last,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic                 matched
);

	cfg_t  cfg_q;
	logic  busy;
	logic  push_valid;
	logic  push_ready;
	item_t push_item;
	logic  q_valid;
	logic  q_pop;
	item_t q_item;

	// Config registers take writes at any time
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.state_count <= STATE_W'(1);
			cfg_q.class_count <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_STATE_COUNT: cfg_q.state_count <= cfg_data[STATE_W-1:0];
				REG_CLASS_COUNT: cfg_q.class_count <= cfg_data[CLASS_W-1:0];
				default:         cfg_q <= cfg_q;
			endcase
		end
	end

	// Decode and range-check incoming beats
	dtbm_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.busy       (busy),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.opcode     (opcode),
		.table_index(table_index),
		.table_value(table_value),
		.data_byte  (data_byte),
		.last       (last),
		.push_valid (push_valid),
		.push_item  (push_item),
		.push_ready (push_ready)
	);

	// Decouples front from the back pipeline
	dtbm_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push_valid(push_valid),
		.push_item (push_item),
		.push_ready(push_ready),
		.pop_valid (q_valid),
		.pop_item  (q_item),
		.pop_ready (q_pop)
	);

	// Tables, state walk and result register
	dtbm_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.q_valid  (q_valid),
		.q_item   (q_item),
		.q_pop    (q_pop),
		.busy     (busy),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.matched  (matched)
	);

endmodule

@@ tb/tb_dfa_table_byte_matcher.sv @@
module tb_dfa_table_byte_matcher;
	timeunit 1ns;
	timeprecision 1ps;
	import dtbm_pkg::*;

	// Opcode and register index that the block leaves unused
	localparam logic [OP_W-1:0]      OP_SPARE  = 3'd7;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;

	// Wait well past the pipeline depth before touching config
	localparam int DRAIN_CYCLES = 20;
	// Covers the table sweep after reset several times over
	localparam int STALL_LIMIT  = 20000;
	localparam int ITEM_TARGET  = 1500;
	// From here on both sides stream without gaps
	localparam int QUIET_FROM   = 1300;
	localparam int NUM_VEC      = 25;

	// Directed row: either a table/match beat or a register write.
	// known/want carry a result typed in by hand; otherwise the
	// automaton model supplies it.
	typedef struct packed {
		int is_cfg;
		int op;
		int idx;
		int val;
		int dbyte;
		int lst;
		int known;
		int want;
	} vec_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [VALUE_W-1:0]   cfg_data = '0;
	logic                 in_valid = 1'b0;
	logic                 in_ready;
	logic [OP_W-1:0]      opcode = '0;
	logic [IDX_IN_W-1:0]  table_index = '0;
	logic [VALUE_W-1:0]   table_value = '0;
	logic [BYTE_W-1:0]    data_byte = '0;
	logic                 last = 1'b0;
	logic                 out_valid;
	logic                 out_ready = 1'b0;
	logic                 matched;

	dfa_table_byte_matcher dut (.*);

	always #2 clk = ~clk;

	// ---------------------------------------------------------------
	// Automaton model: registers, tables and walk state
	// ---------------------------------------------------------------
	logic [STATE_W-1:0] m_states;
	logic [CLASS_W-1:0] m_classes;
	logic [STATE_W-1:0] m_cur;
	bit                 m_rej;
	logic [CLASS_W-1:0] m_cmap  [CLASS_MAP_SIZE];
	logic [STATE_W-1:0] m_trans [TABLE_ENTRIES];
	bit                 m_acc   [MAX_STATE_NUMBER];

	// Accept bits still owed by the block, oldest first
	bit matched_q [$];

	int  errors = 0;
	int  stalled = 0;
	int  beats_sent = 0;
	bit  quiet = 1'b0;
	bit  tx_gaps = 1'b1;
	bit  rx_gaps = 1'b1;
	int  rx_hold = 0;

	vec_t script [NUM_VEC];

	// Apply one input beat to the model. ends says whether a string closed,
	// acc is its accept bit.
	function automatic void dfa_step(input logic [OP_W-1:0] op,
			input logic [IDX_IN_W-1:0] idx, input logic [VALUE_W-1:0] val,
			input logic [BYTE_W-1:0] b, input bit lst, output bit ends, output bit acc);
		int cls;
		int flat;
		ends = 1'b0;
		acc  = 1'b0;
		case (op)
			OP_CLASS_WR: if (idx < CLASS_MAP_SIZE) m_cmap[idx] = val[CLASS_W-1:0];
			OP_TRANS_WR: if (idx < TABLE_ENTRIES) m_trans[idx] = val;
			OP_ACC_WR:   if (idx < MAX_STATE_NUMBER) m_acc[idx] = val[0];
			OP_MATCH: begin
				// once rejected, bytes are dropped until the string closes
				if (!m_rej) begin
					cls  = int'(m_cmap[b]);
					flat = int'(m_states) * (cls - 1) + int'(m_cur) - 1;
					if (cls == 0 || cls > int'(m_classes) || m_cur == 0 ||
							flat >= TABLE_ENTRIES || m_trans[flat] == 0)
						m_rej = 1'b1;
					else
						m_cur = m_trans[flat];
				end
				ends = lst;
			end
			OP_END: ends = 1'b1;
			default: ;
		endcase
		if (ends) begin
			// states past the accept table never accept
			acc = !m_rej && m_cur != 0 && int'(m_cur) <= MAX_STATE_NUMBER &&
				m_acc[int'(m_cur) - 1];
			m_cur = 1;
			m_rej = 1'b0;
		end
	endfunction

	// ---------------------------------------------------------------
	// Drivers
	// ---------------------------------------------------------------

	// Offer one beat, hold it until taken, then book its result (if any).
	task automatic push_beat(input int op, input int idx, input int val, input int b,
			input int lst, input int known, input int want);
		bit ends;
		bit acc;
		cfg_valid <= 1'b0;
		if (!quiet && tx_gaps && $urandom_range(0, 4) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 7)) @(posedge clk);
		end
		in_valid    <= 1'b1;
		opcode      <= OP_W'(op);
		table_index <= IDX_IN_W'(idx);
		table_value <= VALUE_W'(val);
		data_byte   <= BYTE_W'(b);
		last        <= (lst != 0);
		do @(posedge clk); while (!in_ready);
		dfa_step(OP_W'(op), IDX_IN_W'(idx), VALUE_W'(val), BYTE_W'(b), lst != 0, ends, acc);
		if (ends)
			matched_q.push_back(known != 0 ? (want != 0) : acc);
		if (op <= int'(OP_END))
			beats_sent++;
		quiet = beats_sent >= QUIET_FROM;
	endtask

	// Register write; valid is left high for a back-to-back write
	task automatic write_reg(input int ri, input int d);
		cfg_valid <= 1'b1;
		cfg_index <= CFG_IDX_W'(ri);
		cfg_data  <= VALUE_W'(d);
		do @(posedge clk); while (!cfg_ready);
		case (CFG_IDX_W'(ri))
			REG_STATE_COUNT: m_states  = STATE_W'(d);
			REG_CLASS_COUNT: m_classes = CLASS_W'(d);
			default: ;
		endcase
	endtask

	// Block is idle once every owed beat is back and the pipe has flushed
	// any table writes still in flight.
	task automatic settle();
		in_valid  <= 1'b0;
		cfg_valid <= 1'b0;
		while (matched_q.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic push_noise();
		push_beat($urandom_range(0, 7), $urandom_range(0, 4095), $urandom_range(0, 1023),
			$urandom_range(0, 255), $urandom_range(0, 1), 0, 0);
	endtask

	// One phase: pick a config, load a small automaton reachable from
	// state 1, then run strings over mostly mapped bytes.
	task automatic run_phase(input int kind);
		int n_states;
		int n_classes;
		int useful;
		int flat;
		int v;
		int b;
		int len;
		int lst;
		int live_st [$];
		int live_cls [$];
		int live_b [$];
		settle();
		case (kind)
			0: begin n_states = $urandom_range(1, 4);   n_classes = $urandom_range(1, 3); end
			1: begin n_states = $urandom_range(2, 8);   n_classes = $urandom_range(1, 6); end
			2: begin n_states = MAX_STATE_NUMBER;        n_classes = 255; end
			3: begin n_states = 1;                       n_classes = $urandom_range(0, 2); end
			4: begin n_states = $urandom_range(9, 511); n_classes = $urandom_range(1, 12); end
			default: begin
				n_states  = $urandom_range(1, 16);
				n_classes = $urandom_range(100, 255);
			end
		endcase
		write_reg(REG_STATE_COUNT, n_states);
		write_reg(REG_CLASS_COUNT, n_classes);
		if ($urandom_range(0, 2) == 0)
			write_reg(REG_SPARE, $urandom_range(0, 1023));
		tx_gaps = $urandom_range(0, 2) != 0;
		rx_gaps = $urandom_range(0, 2) != 0;

		live_st.push_back(1);
		repeat (3) live_st.push_back($urandom_range(1, n_states));
		if ($urandom_range(0, 1) != 0)
			live_st.push_back(n_states);
		// with a wide stride only the first few classes land inside the table
		useful = n_classes;
		if (TABLE_ENTRIES / n_states < useful)
			useful = TABLE_ENTRIES / n_states;
		if (n_classes > 0) begin
			live_cls.push_back(n_classes);
			repeat (3) live_cls.push_back($urandom_range(1, useful));
		end

		foreach (live_st[i])
			foreach (live_cls[j]) begin
				flat = n_states * (live_cls[j] - 1) + live_st[i] - 1;
				if (flat < TABLE_ENTRIES) begin
					case ($urandom_range(0, 19))
						0, 1: v = 0;
						2: v = $urandom_range(0, 1023);
						default: v = live_st[$urandom_range(0, live_st.size() - 1)];
					endcase
					push_beat(OP_TRANS_WR, flat, v, $urandom_range(0, 255),
						$urandom_range(0, 1), 0, 0);
				end
			end
		foreach (live_st[i])
			push_beat(OP_ACC_WR, live_st[i] - 1, $urandom_range(0, 1023),
				$urandom_range(0, 255), $urandom_range(0, 1), 0, 0);
		repeat (6) begin
			b = $urandom_range(0, 255);
			live_b.push_back(b);
			if (live_cls.size() != 0 && $urandom_range(0, 4) != 0)
				v = live_cls[$urandom_range(0, live_cls.size() - 1)];
			else
				v = $urandom_range(0, 1023);
			push_beat(OP_CLASS_WR, b, v, $urandom_range(0, 255), $urandom_range(0, 1), 0, 0);
		end

		repeat ($urandom_range(15, 35)) begin
			len = $urandom_range(0, 9);
			lst = 0;
			for (int k = 0; k < len; k++) begin
				if ($urandom_range(0, 9) != 0)
					b = live_b[$urandom_range(0, live_b.size() - 1)];
				else
					b = $urandom_range(0, 255);
				lst = (k == len - 1 && $urandom_range(0, 5) != 0) ? 1 : 0;
				push_beat(OP_MATCH, $urandom_range(0, 4095), $urandom_range(0, 1023), b, lst, 0, 0);
				if ($urandom_range(0, 11) == 0)
					push_noise();
			end
			// empty string, or a string cut off by an end beat
			if (lst == 0)
				push_beat(OP_END, $urandom_range(0, 4095), $urandom_range(0, 1023),
					$urandom_range(0, 255), $urandom_range(0, 1), 0, 0);
		end
	endtask

	// ---------------------------------------------------------------
	// Sink side: random ready stalls in bursts of low-ready cycles
	// ---------------------------------------------------------------
	always @(posedge clk) begin
		if (rx_hold != 0) begin
			rx_hold--;
			out_ready <= 1'b0;
		end else if (rx_gaps && !quiet && $urandom_range(0, 5) == 0) begin
			rx_hold = $urandom_range(0, 6);
			out_ready <= 1'b0;
		end else begin
			out_ready <= 1'b1;
		end
	end

	// Result check and stall watchdog. Sampled right after the edge, so
	// every signal still holds its pre-edge value.
	always @(posedge clk) begin
		bit want_m;
		if (arst_n && out_valid && out_ready) begin
			if (matched_q.size() == 0) begin
				$error("matched: no beat expected, actual %0b", matched);
				errors++;
			end else begin
				want_m = matched_q.pop_front();
				if (matched !== want_m) begin
					$error("matched: expected %0b, actual %0b", want_m, matched);
					errors++;
				end
			end
		end
		if ((in_valid && in_ready) || (cfg_valid && cfg_ready) || (out_valid && out_ready))
			stalled = 0;
		else if (++stalled >= STALL_LIMIT) begin
			$display("tb_dfa_table_byte_matcher NOT OK");
			$finish;
		end
	end

	// ---------------------------------------------------------------
	// Main sequence
	// ---------------------------------------------------------------
	initial begin
		int kind;
		m_states  = 1;
		m_classes = 0;
		m_cur     = 1;
		m_rej     = 1'b0;
		foreach (m_cmap[i])  m_cmap[i]  = '0;
		foreach (m_trans[i]) m_trans[i] = '0;
		foreach (m_acc[i])   m_acc[i]   = 1'b0;

		// Directed rows. Stride 512 with 255 classes: class 1 is row 0,
		// class 8 reaches the very last entry, class 255 falls off the table.
		script = '{
			// tables are clear out of reset: nothing accepts
			'{0, OP_END,      0,    0,     0,     0, 1, 0},
			'{0, OP_MATCH,    0,    0,     8'hFF, 1, 1, 0},
			'{0, OP_SPARE,    4095, 1023,  8'hFF, 1, 0, 0},
			'{1, 0, REG_STATE_COUNT, MAX_STATE_NUMBER, 0, 0, 0, 0},
			'{1, 0, REG_CLASS_COUNT, 255,              0, 0, 0, 0},
			// wide class value keeps its low byte
			'{0, OP_CLASS_WR, 255,  1023,  0,     0, 0, 0},
			'{0, OP_CLASS_WR, 0,    1,     0,     0, 0, 0},
			'{0, OP_CLASS_WR, 1,    8,     0,     0, 0, 0},
			'{0, OP_CLASS_WR, 4095, 2,     0,     0, 0, 0},
			'{0, OP_TRANS_WR, 0,    512,   0,     0, 0, 0},
			// top entry leads to a state past the accept table
			'{0, OP_TRANS_WR, 4095, 1023,  0,     0, 0, 0},
			'{0, OP_ACC_WR,   511,  1023,  0,     0, 0, 0},
			'{0, OP_ACC_WR,   0,    1,     0,     0, 0, 0},
			'{0, OP_ACC_WR,   4095, 1,     0,     0, 0, 0},
			'{0, OP_MATCH,    0,    0,     0,     1, 0, 0},
			'{0, OP_MATCH,    0,    0,     0,     0, 0, 0},
			'{0, OP_MATCH,    0,    0,     1,     1, 0, 0},
			'{0, OP_MATCH,    0,    0,     8'hFF, 1, 0, 0},
			'{0, OP_MATCH,    0,    0,     0,     0, 0, 0},
			'{0, OP_END,      0,    0,     0,     0, 0, 0},
			// empty string reports the start state's accept bit
			'{0, OP_END,      0,    0,     0,     0, 1, 1},
			// unmapped byte rejects; the later byte only closes the string
			'{0, OP_MATCH,    0,    0,     2,     0, 0, 0},
			'{0, OP_MATCH,    0,    0,     0,     1, 1, 0},
			// state 512 on class 1 has no transition
			'{0, OP_MATCH,    0,    0,     0,     0, 0, 0},
			'{0, OP_MATCH,    0,    0,     0,     1, 0, 0}
		};

		repeat (6) @(posedge clk);
		@(negedge clk) arst_n <= 1'b1;
		@(posedge clk);

		foreach (script[i]) begin
			if (script[i].is_cfg != 0) begin
				settle();
				write_reg(script[i].idx, script[i].val);
			end else begin
				push_beat(script[i].op, script[i].idx, script[i].val, script[i].dbyte,
					script[i].lst, script[i].known, script[i].want);
			end
		end

		kind = 0;
		while (beats_sent < ITEM_TARGET) begin
			run_phase(kind % 6);
			kind++;
		end

		settle();
		if (errors == 0)
			$display("tb_dfa_table_byte_matcher OK");
		else
			$display("tb_dfa_table_byte_matcher NOT OK");
		$finish;
	end

endmodule

@@ dfa_table_byte_matcher.f @@
design/dtbm_pkg.sv
design/dtbm_queue.sv
design/dtbm_front.sv
design/dtbm_back.sv
design/dfa_table_byte_matcher.sv
tb/tb_dfa_table_byte_matcher.sv
